/* design/r184_pkg.sv */
// shared types and constants for the rule 184 traffic ring
// no dependencies; imported by rule184_traffic_ring
`default_nettype none

package r184_pkg;

    localparam int LEN_W = 11;   // ring length register width
    localparam int IDX_W = 10;   // cell index field width
    localparam int CNT_W = 11;   // moved car count width

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] cell_index;
        logic             cell_value;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0] moved_cars;
        logic             cell_value_out;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_TAIL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* design/r184_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module r184_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/rule184_traffic_ring.sv */
// top level of the rule 184 traffic ring: sequencer, sweep datapath, ports
// depends on r184_pkg and r184_ram
//
// A circular road of one-bit cells (1 = car) held in a 1-bit wide ram of
// MAX_CELLS entries. The active ring is cells 0 .. n-1 with
// n = min(ring_length, MAX_CELLS); cell n-1 wraps to cell 0. Each input word
// gives exactly one result word. A step item, unless no cell is active,
// sweeps the ram one cell per cycle through its single read port, reading
// cell n-1 first, then cells 0 .. n-1, and writes each new cell value back
// behind the read pointer, so old neighbours are always read before they
// are overwritten. The value of cell 0 is kept aside to serve as the
// neighbour ahead of cell n-1. A finished result sits in an output register,
// so the next input word is taken while the previous result still waits.
// After reset the ram is swept to empty, one entry per cycle; input is
// stalled during that pass, configuration writes are taken at any time.
// ring_length must only be written while the block is idle.
`default_nettype none

module rule184_traffic_ring
    import r184_pkg::*;
#(
    parameter int MAX_CELLS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input words
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_word         i_in_word,
    // result words
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_word             o_out_word,
    // ring length register
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    localparam int AW      = $clog2(MAX_CELLS);
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((MAX_CELLS > LEN_MAX) ? LEN_MAX : MAX_CELLS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_CELLS - 1);

    // control registers
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_ring_length;
    logic [AW-1:0]    r_clr_addr;
    logic             r_issue;       // step reads still to be issued
    logic [LEN_W-1:0] r_k;           // step read sequence number
    logic             r_rd_vld;      // ram data valid this cycle
    logic [LEN_W-1:0] r_rd_k;        // sequence number of that data
    logic             r_out_vld;

    // payload registers
    logic             r_w1, r_w2;    // cell behind, cell here
    logic             r_first;       // old value of cell 0
    logic             r_idx_ok;
    t_out_word        r_res;
    t_out_word        r_out_word;

    // ram ports
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic             w_wdata;
    logic [AW-1:0]    w_raddr;
    logic             w_rdata;

    logic [LEN_W-1:0] w_len;
    logic             w_in_acc;
    logic             w_idx_ok;
    logic             w_proc;
    logic             w_last_data;
    logic             w_ahead;
    logic             w_new;
    logic             w_move;
    logic             w_load_out;

    // effective ring length
    assign w_len = (r_ring_length > LEN_CAP) ? LEN_CAP : r_ring_length;

    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_idx_ok    = {1'b0, i_in_word.cell_index} < w_len;
    // a full neighbourhood is present once the third value has arrived
    assign w_proc      = (r_state == ST_STEP) && r_rd_vld && (r_rd_k[LEN_W-1:1] != '0);
    assign w_last_data = (r_state == ST_STEP) && r_rd_vld && (r_rd_k == w_len);

    // rule 184: a car stays if blocked, an empty cell takes the car behind
    assign w_ahead = (r_state == ST_TAIL) ? r_first : w_rdata;
    assign w_new   = r_w2 ? w_ahead : r_w1;
    assign w_move  = r_w2 & ~w_ahead;

    assign w_load_out = (r_state == ST_DONE) && (!r_out_vld || !i_out_stall);

    r184_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_word.opcode)
                        OP_STEP: n_state = (w_len == '0) ? ST_DONE : ST_STEP;
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_STEP: begin
                if (w_last_data) n_state = ST_TAIL;
            end
            ST_TAIL: n_state = ST_DONE;
            ST_DONE: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ram control and handshake outputs
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(i_in_word.cell_index);
        w_wdata = i_in_word.cell_value;
        w_raddr = AW'(i_in_word.cell_index);
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = 1'b0;
            end
            ST_IDLE: begin
                w_we = w_in_acc && (i_in_word.opcode == OP_WRITE) && w_idx_ok;
            end
            ST_STEP: begin
                // first read fetches cell n-1, then cells 0 .. n-1
                w_raddr = (r_k == '0) ? AW'(w_len - 1'b1) : AW'(r_k - 1'b1);
                w_we    = w_proc;
                w_waddr = AW'(r_rd_k - LEN_W'(2));
                w_wdata = w_new;
            end
            ST_TAIL: begin
                w_we    = 1'b1;
                w_waddr = AW'(w_len - 1'b1);
                w_wdata = w_new;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_ring_length <= LEN_W'(1024);
            r_clr_addr    <= '0;
            r_issue       <= 1'b0;
            r_k           <= '0;
            r_rd_vld      <= 1'b0;
            r_rd_k        <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_ring_length <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_in_acc && (i_in_word.opcode == OP_STEP)) begin
                r_issue <= (w_len != '0);
                r_k     <= '0;
            end else if ((r_state == ST_STEP) && r_issue) begin
                r_k <= r_k + 1'b1;
                if (r_k == w_len) r_issue <= 1'b0;
            end
            r_rd_vld <= (r_state == ST_STEP) && r_issue;
            r_rd_k   <= r_k;
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res    <= '0;
            r_idx_ok <= w_idx_ok;
        end
        if (r_state == ST_READ) begin
            r_res.cell_value_out <= r_idx_ok & w_rdata;
        end
        if ((r_state == ST_STEP) && r_rd_vld) begin
            r_w1 <= r_w2;
            r_w2 <= w_rdata;
            if (r_rd_k == LEN_W'(1)) r_first <= w_rdata;
        end
        if (w_proc || (r_state == ST_TAIL)) begin
            r_res.moved_cars <= r_res.moved_cars + CNT_W'(w_move);
        end
        if (w_load_out) begin
            r_out_word <= r_res;
        end
    end

endmodule

`default_nettype wire
